>>> rtl/alsc_pkg.sv
package alsc_pkg;

  // Query and database geometry
  localparam int QUERY_LEN  = 32;
  localparam int DB_LEN     = 65536;
  localparam int ROW_STRIDE = QUERY_LEN + 1;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int SCORE_W  = 7;
  localparam int IDX_W    = 22;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int QUERY_W  = QUERY_LEN * CHAR_W;
  localparam int ROW_W    = $clog2(DB_LEN + 1);
  localparam int MUL_W    = ROW_W + $clog2(ROW_STRIDE + 1);
  localparam int COL_W    = (QUERY_LEN > 1) ? $clog2(QUERY_LEN) : 1;
  // Signed working width for cell arithmetic
  localparam int SUM_W    = SCORE_W + 2;

  // Request queue between front and back
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_3 = 3'd3;

  // Cell traceback direction
  typedef enum logic [1:0] {
    DIR_CENTRE = 2'd0,
    DIR_NORTH  = 2'd1,
    DIR_NW     = 2'd2,
    DIR_WEST   = 2'd3
  } dir_t;

  // One row request as queued for the back end
  typedef struct packed {
    logic [CHAR_W-1:0] db_char;
    logic              new_alignment;
    logic [IDX_W-1:0]  base_idx;
  } alsc_req_t;

endpackage

>>> rtl/alsc_if.sv
interface alsc_in_if;
  import alsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] db_char;
  logic              new_alignment;

  modport source (output valid, output db_char, output new_alignment, input ready);
  modport sink   (input valid, input db_char, input new_alignment, output ready);
endinterface

interface alsc_out_if;
  import alsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic [1:0]         direction;
  logic [IDX_W-1:0]   cell_index;
  logic [SCORE_W-1:0] best_score;
  logic [IDX_W-1:0]   best_index;
  logic               last;

  modport source (output valid, output score, output direction, output cell_index,
                  output best_score, output best_index, output last, input ready);
  modport sink   (input valid, input score, input direction, input cell_index,
                  input best_score, input best_index, input last, output ready);
endinterface

>>> rtl/alsc_front.sv
module alsc_front
  import alsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  alsc_in_if.sink    in_chan,
  input  logic       q_full,
  output logic       q_push,
  output alsc_req_t  q_data
);

  logic [ROW_W-1:0] row_cnt_r;
  logic [ROW_W-1:0] row_cnt_nxt;
  logic [ROW_W-1:0] cnt_base;
  logic [ROW_W-1:0] row;
  logic [MUL_W-1:0] base_full;
  logic             drop;
  logic             accept;

  // Take requests whenever the queue has room
  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Classify: restart the row count on a new alignment, drop rows past the end
  assign cnt_base  = in_chan.new_alignment ? '0 : row_cnt_r;
  assign drop      = (cnt_base >= ROW_W'(DB_LEN));
  assign row       = cnt_base + ROW_W'(1);
  assign base_full = MUL_W'(row) * MUL_W'(ROW_STRIDE);

  assign q_push           = accept && !drop;
  assign q_data.db_char       = in_chan.db_char;
  assign q_data.new_alignment = in_chan.new_alignment;
  assign q_data.base_idx      = IDX_W'(base_full);

  always_comb begin
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      row_cnt_nxt = drop ? cnt_base : row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

>>> rtl/alsc_queue.sv
module alsc_queue
  import alsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  alsc_req_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output alsc_req_t q_data
);

  alsc_req_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/alsc_back.sv
module alsc_back
  import alsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [QUERY_W-1:0] query_vec,
  input  logic               q_valid,
  input  alsc_req_t          q_data,
  output logic               q_pop,
  alsc_out_if.source         out_chan
);

  // Row store and per-row working registers
  logic [SCORE_W-1:0] prev_r [QUERY_LEN];
  logic               busy_r;
  logic               fresh_r;
  logic               zero_r;
  logic [COL_W-1:0]   col_r;
  logic [SCORE_W-1:0] left_r;
  logic [SCORE_W-1:0] diag_r;
  logic [IDX_W-1:0]   idx_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [SCORE_W-1:0] bsf_r;
  logic [IDX_W-1:0]   bpos_r;

  // Output register
  logic               out_valid_r;
  logic [SCORE_W-1:0] score_r;
  dir_t               dir_r;
  logic [IDX_W-1:0]   cidx_r;
  logic [SCORE_W-1:0] bscore_r;
  logic [IDX_W-1:0]   bidx_r;
  logic               last_r;

  logic               step;
  logic               last_col;
  logic [SCORE_W-1:0] up;
  logic [CHAR_W-1:0]  qch;
  logic signed [SUM_W-1:0] north;
  logic signed [SUM_W-1:0] nw;
  logic signed [SUM_W-1:0] west;
  logic signed [SUM_W-1:0] best;
  dir_t               dir_nxt;
  logic [SCORE_W-1:0] best_nxt;
  logic               improve;
  logic [SCORE_W-1:0] bsf_nxt;
  logic [IDX_W-1:0]   bpos_nxt;

  // Compute one cell when the output register is free or being drained
  assign step     = busy_r && (!out_valid_r || out_chan.ready);
  assign last_col = (col_r == COL_W'(QUERY_LEN - 1));
  assign q_pop    = q_valid && (!busy_r || (step && last_col));

  // Cell recurrence
  assign up  = zero_r ? '0 : prev_r[col_r];
  assign qch = query_vec[col_r*CHAR_W +: CHAR_W];

  always_comb begin
    north = $signed({2'b00, up}) - SUM_W'(1);
    nw    = $signed({2'b00, diag_r}) + ((qch == ch_r) ? SUM_W'(2) : -SUM_W'(1));
    west  = $signed({2'b00, left_r}) - SUM_W'(1);
    best    = north;
    dir_nxt = DIR_NORTH;
    if (nw > best) begin
      best    = nw;
      dir_nxt = DIR_NW;
    end
    if (west > best) begin
      best    = west;
      dir_nxt = DIR_WEST;
    end
    if (best <= 0) begin
      best    = '0;
      dir_nxt = DIR_CENTRE;
    end
    best_nxt = best[SCORE_W-1:0];
  end

  // Running best, first strict maximum wins
  assign improve  = (best_nxt > bsf_r);
  assign bsf_nxt  = improve ? best_nxt : bsf_r;
  assign bpos_nxt = improve ? idx_r : bpos_r;

  // Write back the row store
  always_ff @(posedge clk) begin
    if (step) begin
      prev_r[col_r] <= best_nxt;
    end
  end

  // Row sequencing: load the next request on pop, else advance a column per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fresh_r <= 1'b1;
      zero_r  <= 1'b0;
      col_r   <= '0;
      left_r  <= '0;
      diag_r  <= '0;
      idx_r   <= '0;
      ch_r    <= '0;
    end else begin
      if (q_pop) begin
        busy_r  <= 1'b1;
        fresh_r <= 1'b0;
        zero_r  <= fresh_r || q_data.new_alignment;
        col_r   <= '0;
        left_r  <= '0;
        diag_r  <= '0;
        idx_r   <= q_data.base_idx + IDX_W'(1);
        ch_r    <= q_data.db_char;
      end else if (step) begin
        col_r  <= col_r + COL_W'(1);
        idx_r  <= idx_r + IDX_W'(1);
        diag_r <= up;
        left_r <= best_nxt;
        if (last_col) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Track the best cell; drop it when a new alignment is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsf_r  <= '0;
      bpos_r <= '0;
    end else if (q_pop && q_data.new_alignment) begin
      bsf_r  <= '0;
      bpos_r <= '0;
    end else if (step) begin
      bsf_r  <= bsf_nxt;
      bpos_r <= bpos_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      score_r  <= best_nxt;
      dir_r    <= dir_nxt;
      cidx_r   <= idx_r;
      bscore_r <= bsf_nxt;
      bidx_r   <= bpos_nxt;
      last_r   <= last_col;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.score      = score_r;
  assign out_chan.direction  = dir_r;
  assign out_chan.cell_index = cidx_r;
  assign out_chan.best_score = bscore_r;
  assign out_chan.best_index = bidx_r;
  assign out_chan.last       = last_r;

endmodule

>>> rtl/local_alignment_scorer.sv
// Smith-Waterman local alignment scorer, linear gap, one database character per request.
// A request is queued, loaded into the row registers, and its first cell registered out.
// Throughput: 32 cells a row, one per cycle from a single cell unit, unless output stalls.
// Rows past the database length are dropped in the front end and never reach the back end.
// Reset (synchronous, rst_n low) zeroes the query registers, row count and best.
module local_alignment_scorer
  import alsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  alsc_in_if.sink              in_chan,
  alsc_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0]   query_r [4];
  logic [4*CFG_W-1:0] query_all;
  logic [QUERY_W-1:0] query_vec;
  logic               q_full;
  logic               q_push;
  alsc_req_t          push_data;
  logic               q_pop;
  logic               q_valid;
  alsc_req_t          q_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r[0] <= '0;
      query_r[1] <= '0;
      query_r[2] <= '0;
      query_r[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY_0: query_r[0] <= cfg_wdata;
        CFG_QUERY_1: query_r[1] <= cfg_wdata;
        CFG_QUERY_2: query_r[2] <= cfg_wdata;
        CFG_QUERY_3: query_r[3] <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  assign query_all = {query_r[3], query_r[2], query_r[1], query_r[0]};
  assign query_vec = query_all[QUERY_W-1:0];

  alsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (push_data)
  );

  alsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  alsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .query_vec (query_vec),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_chan  (out_chan)
  );

endmodule
